/* design/lsch_pkg.sv */
// Shared widths, operation codes and controller/datapath bundles of the lottery scheduler.
package lsch_pkg;

   localparam int DEFAULT_MAX_PROCESSES = 16;

   localparam int OP_W     = 1;
   localparam int ENTRY_W  = 4;
   localparam int TICKET_W = 16;
   localparam int RUN_W    = 16;
   localparam int RND_W    = 31;
   localparam int TOTAL_W  = 20;
   localparam int PCNT_W   = 5;

   localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OP_W-1:0] OP_DRAW = 1'b1;

   // restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = RND_W;
   localparam int DIVCNT_W  = $clog2(DIV_STEPS);

   typedef struct packed {
      logic cfg_write;
      logic capture;
      logic mem_load;
      logic sum_clear;
      logic scan_issue;
      logic acc_sum;
      logic acc_walk;
      logic div_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic issue_last;
      logic div_last;
      logic total_zero;
   } status_type;

endpackage

/* design/lsch_if.sv */
// Request, response and register-write channel interfaces of the lottery scheduler.
interface lsch_req_if import lsch_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [ENTRY_W-1:0]  entry_index;
   logic [TICKET_W-1:0] tickets;
   logic [RUN_W-1:0]    run_length;
   logic [RND_W-1:0]    random_value;

   modport source (output valid, op, entry_index, tickets, run_length, random_value,
                   input ready);
   modport sink (input valid, op, entry_index, tickets, run_length, random_value,
                 output ready);
endinterface

interface lsch_rsp_if import lsch_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ran;
   logic [ENTRY_W-1:0] winner;
   logic               finished;
   logic [RUN_W-1:0]   remaining;
   logic               all_done;

   modport source (output valid, ran, winner, finished, remaining, all_done, input ready);
   modport sink (input valid, ran, winner, finished, remaining, all_done, output ready);
endinterface

interface lsch_csr_if import lsch_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PCNT_W-1:0] process_count;

   modport source (output valid, process_count, input ready);
   modport sink (input valid, process_count, output ready);
endinterface

/* design/lsch_datapath.sv */
// Datapath: entry memories, ticket total, serial divider, table walk and response register.
module lsch_datapath import lsch_pkg::*; #(
   parameter int MAX_PROCESSES = DEFAULT_MAX_PROCESSES
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [ENTRY_W-1:0]  req_entry_index,
   input  logic [TICKET_W-1:0] req_tickets,
   input  logic [RUN_W-1:0]    req_run_length,
   input  logic [RND_W-1:0]    req_random_value,
   input  logic [PCNT_W-1:0]   csr_process_count,
   output logic                rsp_ran,
   output logic [ENTRY_W-1:0]  rsp_winner,
   output logic                rsp_finished,
   output logic [RUN_W-1:0]    rsp_remaining,
   output logic                rsp_all_done
);

   localparam int IDX_W = $clog2(MAX_PROCESSES);
   localparam int CUM_W = TICKET_W + IDX_W;
   localparam int TGT_W = TOTAL_W + 1;
   localparam int CMP_W = (CUM_W > TGT_W) ? CUM_W : TGT_W;

   logic [TICKET_W-1:0] tick_mem [MAX_PROCESSES];
   logic [RUN_W-1:0]    rmn_mem  [MAX_PROCESSES];

   logic [PCNT_W-1:0]   pcnt_ff;
   logic [TOTAL_W-1:0]  total_ff;
   logic [ENTRY_W-1:0]  ld_idx_ff;
   logic [TICKET_W-1:0] ld_tick_ff;
   logic [RUN_W-1:0]    ld_run_ff;
   logic [RND_W-1:0]    dvd_ff, dvd_in;
   logic [TOTAL_W-1:0]  rem_ff, rem_in;
   logic [DIVCNT_W-1:0] dcnt_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                rd_vld_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [TICKET_W-1:0] rd_tick_ff;
   logic [RUN_W-1:0]    rd_rmn_ff;
   logic [CUM_W-1:0]    cum_ff, cum_in;
   logic                found_ff;
   logic                any_left_ff;
   logic [IDX_W-1:0]    win_ff;
   logic [RUN_W-1:0]    win_rmn_ff;
   logic                rsp_ran_ff;
   logic [ENTRY_W-1:0]  rsp_winner_ff;
   logic                rsp_finished_ff;
   logic [RUN_W-1:0]    rsp_remaining_ff;
   logic                rsp_all_done_ff;

   logic [IDX_W-1:0]    last_idx;
   logic                ld_in_range;
   logic [TGT_W-1:0]    rem_sh, rem_diff, target;
   logic                rem_ge;
   logic [RUN_W-1:0]    rmn_dec;
   logic                hit, left_here;
   logic                walk_vld;
   logic                tick_we, rmn_we;
   logic [IDX_W-1:0]    waddr;
   logic [RUN_W-1:0]    rmn_wdata;

   // entries in use, clamped to 1..MAX_PROCESSES, as the last index
   always_comb begin
      if (pcnt_ff == '0) begin
         last_idx = '0;
      end else if (32'(pcnt_ff) > 32'(MAX_PROCESSES)) begin
         last_idx = IDX_W'(MAX_PROCESSES - 1);
      end else begin
         last_idx = IDX_W'(pcnt_ff - PCNT_W'(1));
      end
   end

   assign ld_in_range = 32'(ld_idx_ff) < 32'(MAX_PROCESSES);

   // restoring division step
   assign rem_sh   = {rem_ff, dvd_ff[RND_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, total_ff};
   assign rem_diff = rem_sh - {1'b0, total_ff};
   assign rem_in   = rem_ge ? rem_diff[TOTAL_W-1:0] : rem_sh[TOTAL_W-1:0];
   assign dvd_in   = {dvd_ff[RND_W-2:0], 1'b0};

   // walk
   assign target    = {1'b0, rem_ff} + TGT_W'(1);
   assign cum_in    = cum_ff + CUM_W'(rd_tick_ff);
   assign rmn_dec   = rd_rmn_ff - RUN_W'(1);
   assign walk_vld  = cmd.acc_walk && rd_vld_ff;
   assign hit       = !found_ff && (total_ff != '0) && (CMP_W'(cum_in) >= CMP_W'(target))
                      && (rd_rmn_ff != '0);
   assign left_here = hit ? (rmn_dec != '0) : (rd_rmn_ff != '0);

   assign tick_we   = cmd.mem_load && ld_in_range;
   assign rmn_we    = tick_we || (walk_vld && hit);
   assign waddr     = cmd.mem_load ? IDX_W'(ld_idx_ff) : rd_idx_ff;
   assign rmn_wdata = cmd.mem_load ? ld_run_ff : rmn_dec;

   always_ff @(posedge clock) begin
      if (tick_we) begin
         tick_mem[waddr] <= ld_tick_ff;
      end
      rd_tick_ff <= tick_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (rmn_we) begin
         rmn_mem[waddr] <= rmn_wdata;
      end
      rd_rmn_ff <= rmn_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff   <= PCNT_W'(1);
         total_ff  <= '0;
         rd_vld_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         if (cmd.cfg_write) begin
            pcnt_ff <= csr_process_count;
         end
         if (cmd.sum_clear) begin
            total_ff <= '0;
         end else if (cmd.acc_sum && rd_vld_ff) begin
            total_ff <= total_ff + TOTAL_W'(rd_tick_ff);
         end
         rd_vld_ff <= cmd.scan_issue;
         if (cmd.capture || cmd.sum_clear) begin
            idx_ff <= '0;
         end else if (cmd.scan_issue) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (cmd.capture) begin
         ld_idx_ff   <= req_entry_index;
         ld_tick_ff  <= req_tickets;
         ld_run_ff   <= req_run_length;
         dvd_ff      <= req_random_value;
         rem_ff      <= '0;
         dcnt_ff     <= '0;
         cum_ff      <= '0;
         found_ff    <= 1'b0;
         any_left_ff <= 1'b0;
      end else begin
         if (cmd.div_step) begin
            dvd_ff  <= dvd_in;
            rem_ff  <= rem_in;
            dcnt_ff <= dcnt_ff + DIVCNT_W'(1);
         end
         if (walk_vld) begin
            cum_ff <= cum_in;
            if (hit) begin
               found_ff   <= 1'b1;
               win_ff     <= rd_idx_ff;
               win_rmn_ff <= rmn_dec;
            end
            if (left_here) begin
               any_left_ff <= 1'b1;
            end
         end
      end
      if (cmd.rsp_load) begin
         rsp_ran_ff       <= found_ff;
         rsp_winner_ff    <= found_ff ? ENTRY_W'(win_ff) : '0;
         rsp_finished_ff  <= found_ff && (win_rmn_ff == '0);
         rsp_remaining_ff <= found_ff ? win_rmn_ff : '0;
         rsp_all_done_ff  <= !any_left_ff;
      end
   end

   assign status.issue_last = idx_ff == last_idx;
   assign status.div_last   = dcnt_ff == DIVCNT_W'(DIV_STEPS - 1);
   assign status.total_zero = total_ff == '0;

   assign rsp_ran       = rsp_ran_ff;
   assign rsp_winner    = rsp_winner_ff;
   assign rsp_finished  = rsp_finished_ff;
   assign rsp_remaining = rsp_remaining_ff;
   assign rsp_all_done  = rsp_all_done_ff;

endmodule

/* design/lsch_ctrl.sv */
// Controller: sequences loads, total refresh, division, table walk and response handoff.
module lsch_ctrl import lsch_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   input  logic            csr_valid,
   output logic            csr_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  status_type      status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_SUM_TAIL,
      ST_DIV,
      ST_WALK,
      ST_WALK_TAIL,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire, csr_fire;

   assign csr_ready = state_ff == ST_IDLE;
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               cmd.cfg_write = 1'b1;
               cmd.sum_clear = 1'b1;
               state_in      = ST_SUM;
            end else if (req_fire) begin
               cmd.capture = 1'b1;
               state_in    = (req_op == OP_DRAW) ? ST_DIV : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.mem_load  = 1'b1;
            cmd.sum_clear = 1'b1;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            cmd.scan_issue = 1'b1;
            cmd.acc_sum    = 1'b1;
            if (status.issue_last) begin
               state_in = ST_SUM_TAIL;
            end
         end
         ST_SUM_TAIL: begin
            cmd.acc_sum = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_DIV: begin
            if (status.total_zero) begin
               state_in = ST_WALK;
            end else begin
               cmd.div_step = 1'b1;
               if (status.div_last) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.scan_issue = 1'b1;
            cmd.acc_walk   = 1'b1;
            if (status.issue_last) begin
               state_in = ST_WALK_TAIL;
            end
         end
         ST_WALK_TAIL: begin
            cmd.acc_walk = 1'b1;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_rsp_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("response load did not raise valid");

   a_draw_to_div: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_DRAW)) |=> (state_ff == ST_DIV))
      else $error("draw request did not start division");

   a_csr_to_sum: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> (state_ff == ST_SUM))
      else $error("register write did not start total refresh");

   a_one_accept: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && csr_fire))
      else $error("request and register write taken together");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.rsp_load)
      else $error("pending response overwritten");
`endif

endmodule

/* design/lottery_scheduler_top.sv */
// Top level of the lottery scheduler: controller plus datapath behind three channels.
//
// Lottery scheduler. A table of up to MAX_PROCESSES entries (2..16) holds a
// 16-bit ticket count and a 16-bit remaining run time per process, in two
// simple dual-port memories (one write and one registered read per cycle). A
// load request (op 0) writes one entry; a draw request (op 1) reduces
// random_value modulo the ticket total,
// adds one to get the winning ticket, walks the running ticket sums of the
// entries in use and runs the first entry whose sum reaches the winning ticket
// and whose remaining time is nonzero. Each draw returns one response; loads
// return none. The csr channel writes process_count; 0 acts as 1 and values
// above MAX_PROCESSES act as MAX_PROCESSES. With n entries in use, a load
// occupies the block for accept, memory write, n reads and a tail, and a
// register write for accept, n reads and a tail, both spent re-summing the
// ticket total over the table. A draw runs the bit-serial restoring divider
// (which takes no division steps when the total is zero), walks the table
// through the memory read port with n reads, then passes a tail and a
// response step, which waits while an earlier response is still held. The
// response sits in an output register, so the next request is taken while it waits.
// Register writes are taken ahead of requests when both are offered. Table
// entries hold no reset value: a draw over entries that were never loaded
// gives undefined fields.
module lottery_scheduler_top import lsch_pkg::*; #(
   parameter int MAX_PROCESSES = DEFAULT_MAX_PROCESSES
) (
   input logic         clock,
   input logic         reset,
   lsch_req_if.sink    req_ch,
   lsch_rsp_if.source  rsp_ch,
   lsch_csr_if.sink    csr_ch
);

   cmd_type    cmd;
   status_type status;

   // sequencing of every request and register write
   lsch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table memories, total, divider, walk and response register
   lsch_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_entry_index   (req_ch.entry_index),
      .req_tickets       (req_ch.tickets),
      .req_run_length    (req_ch.run_length),
      .req_random_value  (req_ch.random_value),
      .csr_process_count (csr_ch.process_count),
      .rsp_ran           (rsp_ch.ran),
      .rsp_winner        (rsp_ch.winner),
      .rsp_finished      (rsp_ch.finished),
      .rsp_remaining     (rsp_ch.remaining),
      .rsp_all_done      (rsp_ch.all_done)
   );

endmodule

/* tb/lsch_checker.sv */
// Checker for the lottery scheduler: mirrors the process table and scores every draw response.
module lsch_checker import lsch_pkg::*; #(
   parameter int MAX_PROCESSES = DEFAULT_MAX_PROCESSES
) (
   input  logic        clock,
   input  logic        reset,
   lsch_req_if         req_mon,
   lsch_rsp_if         rsp_mon,
   lsch_csr_if         csr_mon,
   output int unsigned error_count,
   output int unsigned draws_pending
);

   typedef struct packed {
      logic               ran;
      logic [ENTRY_W-1:0] winner;
      logic               finished;
      logic [RUN_W-1:0]   remaining;
      logic               all_done;
   } draw_result_type;

   logic [TICKET_W-1:0] ticket_tab [MAX_PROCESSES];
   logic [RUN_W-1:0]    time_left  [MAX_PROCESSES];
   logic [TOTAL_W-1:0]  ticket_sum;
   logic [PCNT_W-1:0]   proc_count;
   draw_result_type     draw_results_q [$];

   // count register is clamped to 1..MAX_PROCESSES
   function automatic int unsigned entries_in_use();
      int unsigned n;
      n = proc_count;
      if (n < 1) n = 1;
      if (n > MAX_PROCESSES) n = MAX_PROCESSES;
      return n;
   endfunction

   function automatic void resum_tickets();
      logic [31:0] acc;
      acc = '0;
      for (int i = 0; i < entries_in_use(); i++) acc += 32'(ticket_tab[i]);
      ticket_sum = acc[TOTAL_W-1:0];
   endfunction

   // winning ticket, walk of running sums, skip of finished entries
   function automatic draw_result_type run_draw(input logic [RND_W-1:0] rnd);
      draw_result_type res;
      int unsigned     n;
      logic [31:0]     target;
      logic [31:0]     running;
      res          = '0;
      res.all_done = 1'b1;
      n            = entries_in_use();
      if (ticket_sum != '0) begin
         target  = 32'(rnd) % 32'(ticket_sum) + 32'd1;
         running = '0;
         for (int i = 0; i < n; i++) begin
            running += 32'(ticket_tab[i]);
            if (running >= target && time_left[i] != '0) begin
               time_left[i]  = time_left[i] - 1'b1;
               res.ran       = 1'b1;
               res.winner    = i[ENTRY_W-1:0];
               res.remaining = time_left[i];
               res.finished  = (time_left[i] == '0);
               break;
            end
         end
      end
      for (int i = 0; i < n; i++)
         if (time_left[i] != '0) res.all_done = 1'b0;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      draw_result_type want;
      if (reset) begin
         proc_count  = 5'd1;
         ticket_sum  = '0;
         error_count = 0;
         draw_results_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (draw_results_q.size() == 0) begin
               $error("response with no draw outstanding");
               error_count++;
            end else begin
               want = draw_results_q.pop_front();
               check_field("ran", 32'(want.ran), 32'(rsp_mon.ran));
               check_field("winner", 32'(want.winner), 32'(rsp_mon.winner));
               check_field("finished", 32'(want.finished), 32'(rsp_mon.finished));
               check_field("remaining", 32'(want.remaining), 32'(rsp_mon.remaining));
               check_field("all_done", 32'(want.all_done), 32'(rsp_mon.all_done));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            proc_count = csr_mon.process_count;
            resum_tickets();
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == OP_LOAD) begin
               if (32'(req_mon.entry_index) < MAX_PROCESSES) begin
                  ticket_tab[req_mon.entry_index] = req_mon.tickets;
                  time_left[req_mon.entry_index]  = req_mon.run_length;
                  resum_tickets();
               end
            end else begin
               draw_results_q.push_back(run_draw(req_mon.random_value));
            end
         end
      end
      draws_pending = draw_results_q.size();
   end

endmodule

/* tb/lottery_scheduler_top_tb.sv */
// Testbench top for the lottery scheduler: reset, stimulus, handshake pacing and verdict.
module lottery_scheduler_top_tb;
   import lsch_pkg::*;

   localparam int MAX_PROC      = DEFAULT_MAX_PROCESSES;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int PHASES        = 3;
   // worst single request is a draw over all 16 entries
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 1000000;

   logic clock;
   logic reset;

   lsch_req_if req_ch ();
   lsch_rsp_if rsp_ch ();
   lsch_csr_if csr_ch ();

   int unsigned fail_count;
   int unsigned draws_pending;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned cycle_count = 0;

   lottery_scheduler_top #(.MAX_PROCESSES(MAX_PROC)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // checker sits beside the block and only watches the three channels
   lsch_checker #(.MAX_PROCESSES(MAX_PROC)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .error_count   (fail_count),
      .draws_pending (draws_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: sized well above the slowest legal run (every draw at full
   // table size, receiver stalls and sender gaps included).
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response back-pressure: a fresh ready decision every cycle, so stalls land on
   // held responses and on the result step of a draw. The idle rate is set per phase.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Ticket mix: some tiny (zero possible), some mid, many across all 16 bits.
   function automatic logic [TICKET_W-1:0] pick_tickets();
      case ($urandom_range(3))
         0:       return TICKET_W'($urandom_range(8));
         1:       return TICKET_W'($urandom_range(255, 1));
         default: return TICKET_W'($urandom);
      endcase
   endfunction

   // Mostly short jobs so entries finish and all_done toggles; a few long ones.
   function automatic logic [RUN_W-1:0] pick_run();
      int unsigned sel;
      sel = $urandom_range(7);
      if (sel == 0) return '0;
      if (sel == 7) return RUN_W'($urandom);
      return RUN_W'(sel);
   endfunction

   // One request. valid is only lowered when a gap is actually taken, so a
   // back-to-back request never sees valid dropped and raised in one step.
   task automatic send_request(input logic [OP_W-1:0]     op,
                               input logic [ENTRY_W-1:0]  idx,
                               input logic [TICKET_W-1:0] tickets,
                               input logic [RUN_W-1:0]    run,
                               input logic [RND_W-1:0]    rnd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.entry_index  <= idx;
      req_ch.tickets      <= tickets;
      req_ch.run_length   <= run;
      req_ch.random_value <= rnd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_draw(input logic [RND_W-1:0] rnd);
      send_request(OP_DRAW, ENTRY_W'($urandom), TICKET_W'($urandom), RUN_W'($urandom), rnd);
   endtask

   task automatic send_load(input logic [ENTRY_W-1:0] idx, input logic [TICKET_W-1:0] tickets,
                            input logic [RUN_W-1:0] run);
      send_request(OP_LOAD, idx, tickets, run, RND_W'($urandom));
   endtask

   // Drain: all draws answered, then enough cycles for a trailing load's
   // re-sum to finish (loads give no response to wait on).
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (draws_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // process_count is only changed with the block idle
   task automatic write_count(input logic [PCNT_W-1:0] value);
      settle();
      csr_ch.valid         <= 1'b1;
      csr_ch.process_count <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned       active;
      int unsigned       phase_items;
      int unsigned       draw_burst;
      logic [PCNT_W-1:0] count_sel;

      req_ch.valid         <= 1'b0;
      req_ch.op            <= OP_LOAD;
      req_ch.entry_index   <= '0;
      req_ch.tickets       <= '0;
      req_ch.run_length    <= '0;
      req_ch.random_value  <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.process_count <= '0;
      reset                <= 1'b1;
      send_idle_pct = 29;
      recv_idle_pct = 87;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part; count is 1 out of reset, so only entry 0 is in use ----
      // zero tickets -> zero total, nothing runs, entry 0 still has time left
      send_load(4'd0, 16'd0, 16'd5);
      send_draw('0);
      // single ticket, single unit: runs and finishes, everything done
      send_load(4'd0, 16'd1, 16'd1);
      send_draw({RND_W{1'b1}});
      // only entry is finished: no winner, all_done stays high
      send_draw('0);
      // field maxima
      send_load(4'd0, 16'hFFFF, 16'hFFFF);
      send_draw({RND_W{1'b1}});

      // Fill the rest of the table while only entry 0 counts (loads past
      // the count). Every third entry gets no run time; entry 15 holds max tickets.
      for (int e = 1; e < MAX_PROC; e++)
         send_load(ENTRY_W'(e), (e == MAX_PROC - 1) ? 16'hFFFF : TICKET_W'(e),
                   RUN_W'(e % 3));

      // count 0 behaves as 1
      write_count(5'd0);
      send_draw({RND_W{1'b1}});
      // count above range behaves as the full table
      write_count(5'd31);
      send_draw('0);
      // Winning ticket lands on entry 3, which has no time left; the turn
      // passes to entry 4, which then finishes.
      send_draw(RND_W'(32'h10004));
      write_count(5'd16);
      send_draw({RND_W{1'b1}});
      write_count(5'd17);
      send_draw(RND_W'($urandom));

      // ---- random part: three pacing phases ----
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / PHASES) begin
            // new table size, out-of-range codes included
            count_sel = PCNT_W'($urandom_range(31));
            write_count(count_sel);
            active = (count_sel == '0) ? 1 : ((count_sel > MAX_PROC) ? MAX_PROC : count_sel);

            // fresh jobs on most entries in use
            for (int e = 0; e < active; e++) begin
               if ($urandom_range(3) != 0) begin
                  send_load(ENTRY_W'(e), pick_tickets(), pick_run());
                  phase_items++;
               end
            end

            // draw run, with the odd load thrown in anywhere in the table
            draw_burst = $urandom_range(40, 8);
            repeat (draw_burst) begin
               if ($urandom_range(9) == 0)
                  send_load(ENTRY_W'($urandom), pick_tickets(), pick_run());
               else
                  send_draw(RND_W'($urandom));
               phase_items++;
            end
         end
      end

      settle();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
design/lsch_pkg.sv
design/lsch_if.sv
design/lsch_datapath.sv
design/lsch_ctrl.sv
design/lottery_scheduler_top.sv
tb/lsch_checker.sv
tb/lottery_scheduler_top_tb.sv
